[src/spsel_pkg.sv]
// Shared types, widths and register indexes for the sorted prefix select block.
`default_nettype none
package spsel_pkg;

  localparam int PRIZE_W = 17;
  localparam int RANK_W = 16;
  localparam int IDX_W = 6;
  localparam int TGT_W = 24;
  localparam int SUM_W = 23;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int MAX_NODES_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PINNED_INDEX = 2'd1;

  typedef struct packed {
    logic [PRIZE_W-1:0] prize;
    logic [RANK_W-1:0] rank;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic [PRIZE_W-1:0] out_prize;
    logic [RANK_W-1:0] out_rank;
    logic [IDX_W-1:0] out_index;
    logic out_last;
  } out_item_t;

  // One slot of the sorting chain.
  typedef struct packed {
    logic valid;
    logic pin;
    logic [PRIZE_W-1:0] prize;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0] idx;
  } node_t;

  // Chain control, common to all cells.
  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } chain_ctrl_t;

endpackage
`default_nettype wire

[src/sorted_prefix_select_to_target.sv]
// Top level: load, insertion-sort chain, prefix emission to a target sum.
// Nodes load at one beat per cycle into a chain of MAX_NODES cells that keeps
// them sorted as they arrive (pinned node first, then prize high to low, ties
// in load order); the last beat starts selection if target_sum[23] is 0 and
// pinned_index < node count, else it clears the chain. Selection shifts the
// chain head out, one result beat per cycle while out_ready is high, until
// the running prize sum reaches target_sum or the set runs out. in_ready is
// low during emission and rises once the final result beat is in the output
// register. cfg_ready is always high; write registers only between sets.
`default_nettype none
module sorted_prefix_select_to_target #(
  parameter int MAX_NODES = spsel_pkg::MAX_NODES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  spsel_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output spsel_pkg::out_item_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spsel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spsel_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spsel_pkg::*;

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state;
  logic [TGT_W-1:0] target_sum;
  logic [IDX_W-1:0] pinned_index;
  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] remain;
  logic [SUM_W-1:0] running_sum;

  node_t chain [MAX_NODES];
  logic lt_v [MAX_NODES];
  chain_ctrl_t ctrl;
  node_t new_node;
  node_t empty_node;

  logic in_acc;
  logic full;
  logic [CNT_W-1:0] count_after;
  logic start_ok;
  logic emit_go;
  logic [SUM_W-1:0] sum_next;
  logic stop;
  logic done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
      pinned_index <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET_SUM:   target_sum <= cfg_data[TGT_W-1:0];
        REG_PINNED_INDEX: pinned_index <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == ST_LOAD);
  assign in_acc = in_valid && in_ready;
  assign full = (node_count == CNT_W'(MAX_NODES));
  assign count_after = full ? node_count : node_count + CNT_W'(1);
  assign start_ok = !target_sum[TGT_W-1] &&
                    (CMP_W'(pinned_index) < CMP_W'(count_after));

  always_comb begin
    new_node.valid = 1'b1;
    new_node.pin = (IDX_W'(node_count) == pinned_index);
    new_node.prize = in_data.prize;
    new_node.rank = in_data.rank;
    new_node.idx = IDX_W'(node_count);
    empty_node = new_node;
    empty_node.valid = 1'b0;
  end

  assign emit_go = (state == ST_EMIT) && (!out_valid || out_ready);
  assign sum_next = running_sum + SUM_W'(chain[0].prize);
  assign stop = ({1'b0, sum_next} >= target_sum);
  assign done = emit_go && (stop || remain == CNT_W'(1));

  always_comb begin
    ctrl.ins = in_acc && !full;
    ctrl.shift = emit_go;
    ctrl.clr = done || (in_acc && in_data.last && !start_ok);
  end

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    node_t prev_n;
    node_t next_n;
    logic prev_l;
    if (i == 0) begin : g_head
      assign prev_n = empty_node;
      assign prev_l = 1'b0;
    end else begin : g_mid
      assign prev_n = chain[i-1];
      assign prev_l = lt_v[i-1];
    end
    if (i == MAX_NODES - 1) begin : g_tail
      assign next_n = empty_node;
    end else begin : g_body
      assign next_n = chain[i+1];
    end
    spsel_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_node  (new_node),
      .prev_node (prev_n),
      .prev_lt   (prev_l),
      .next_node (next_n),
      .node      (chain[i]),
      .lt        (lt_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      node_count <= '0;
      remain <= '0;
      running_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_go || (out_valid && !out_ready);
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (in_data.last) begin
              node_count <= '0;
              running_sum <= '0;
              remain <= count_after;
              if (start_ok) begin
                state <= ST_EMIT;
              end
            end else begin
              node_count <= count_after;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            remain <= remain - CNT_W'(1);
            if (done) begin
              state <= ST_LOAD;
              running_sum <= '0;
            end else begin
              running_sum <= sum_next;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data.out_prize <= chain[0].prize;
      out_data.out_rank <= chain[0].rank;
      out_data.out_index <= chain[0].idx;
      out_data.out_last <= stop || (remain == CNT_W'(1));
    end
  end
endmodule
`default_nettype wire

[src/spsel_cell.sv]
// One cell of the insertion chain: holds a node, takes a new node or its neighbor's.
`default_nettype none
module spsel_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  spsel_pkg::chain_ctrl_t ctrl,
  input  spsel_pkg::node_t     new_node,
  input  spsel_pkg::node_t     prev_node,
  input  logic                 prev_lt,
  input  spsel_pkg::node_t     next_node,
  output spsel_pkg::node_t     node,
  output logic                 lt
);
  import spsel_pkg::*;

  // New node sorts ahead of this slot: pinned first, then higher prize;
  // equal keys stay put so load order holds.
  assign lt = !node.valid || ({node.pin, node.prize} < {new_node.pin, new_node.prize});

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      node.valid <= 1'b0;
    end else if (ctrl.shift) begin
      node <= next_node;
    end else if (ctrl.ins && lt) begin
      node <= prev_lt ? prev_node : new_node;
    end
  end
endmodule
`default_nettype wire
